FILE: hw/rtl/bb3_pkg.sv
// Shared types and constants of the 3x3 RGB box blur.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bb3_pkg;

   // Channel order in a packed pixel: [2] red, [1] green, [0] blue.
   typedef logic [2:0][7:0] rgb_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_word_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       frame_end;
   } rsp_word_type;

   // One column push handed from the front end to the window back end.
   typedef struct packed {
      rgb_type upper;
      rgb_type middle;
      rgb_type pix;
      logic    due;
      logic    last;
   } qent_type;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [10:0] IMAGE_WIDTH_RESET  = 11'd640;
   localparam logic [15:0] IMAGE_HEIGHT_RESET = 16'd480;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Sums stay below 2296, so ceil(2^16 / d) gives exact floors for d = 3 and 9.
   localparam logic [14:0] DIV3_RECIP  = 15'd21846;
   localparam logic [14:0] DIV9_RECIP  = 15'd7282;
   localparam int          RECIP_SHIFT = 16;

endpackage

`default_nettype wire

FILE: hw/rtl/box_blur_3x3_rgb_unit.sv
// Top level of the 3x3 RGB box blur: register port, geometry clamp and the
// front end, queue and back end. Depends on bb3_pkg, bb3_front, bb3_queue, bb3_back.
//
// Usage:
//  - Program image_width (byte address 0) and image_height (address 4) on the
//    csr_ port while the block is idle. Each write restarts the frame; the
//    line stores keep their contents. Width 0 acts as 1, width above
//    MAX_WIDTH as MAX_WIDTH, height 0 as 1.
//  - Send the frame's pixels on req_ in raster order (opcode pixel), then
//    width + 1 flush words to drain. Flush words before the last pixel and
//    pixel words after it are taken and dropped.
//  - Each blurred pixel leaves on rsp_ in raster order, one row and one pixel
//    behind the input; the frame's last one carries frame_end.
//  - A result passes the front register, queue, window, sum and divide after
//    the word that causes it. Throughput is one word per clock while no stall
//    holds; the line store's read and write ports are fed from a one-word front
//    register with forwarding for back-to-back same-column use.
//  - When rsp_stall holds, the back end freezes, the four-entry queue fills,
//    and req_stall rises; no word is lost.
//  - Reset clears the counters, window and pipeline; the line stores hold no
//    defined data until written, which only ever feeds masked positions.
`default_nettype none

module box_blur_3x3_rgb_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // input words
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire bb3_pkg::req_word_type  req_word,
   // result words
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output bb3_pkg::rsp_word_type       rsp_word,
   // register port
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [2:0]             csr_paddr,
   input  wire logic [31:0]            csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import bb3_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int XW = (CW > 11) ? CW : 11;

   logic [10:0]       width_ff;
   logic [15:0]       height_ff;
   logic              csr_write, restart;
   logic              reg_sel;
   logic [XW-1:0]     width_ext;
   logic [CW-1:0]     eff_width;
   logic [15:0]       eff_height;

   logic              q_push, q_full, q_pop, q_valid;
   qent_type          q_in, q_head;

   // Word-aligned decode: address bit 2 picks the register.
   always_comb begin
      csr_pready = 1'b1;
      csr_write  = csr_psel && csr_penable && csr_pwrite;
      reg_sel    = csr_paddr[2];
      restart    = csr_write;
      case (reg_sel)
         REG_IMAGE_WIDTH:  csr_prdata = {21'b0, width_ff};
         REG_IMAGE_HEIGHT: csr_prdata = {16'b0, height_ff};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_WIDTH_RESET;
         height_ff <= IMAGE_HEIGHT_RESET;
      end else if (csr_write) begin
         case (reg_sel)
            REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[10:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[15:0];
            default:          ;
         endcase
      end
   end

   // Clamp the geometry into the range the datapath supports.
   always_comb begin
      width_ext = XW'(width_ff);
      if (width_ext == '0) begin
         eff_width = CW'(1);
      end else if (width_ext > XW'(MAX_WIDTH)) begin
         eff_width = CW'(MAX_WIDTH);
      end else begin
         eff_width = width_ext[CW-1:0];
      end
      eff_height = (height_ff == '0) ? 16'd1 : height_ff;
   end

   bb3_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .eff_width  (eff_width),
      .eff_height (eff_height),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .q_push     (q_push),
      .q_entry    (q_in),
      .q_full     (q_full)
   );

   bb3_queue u_queue (
      .clock      (clock),
      .reset      (reset || restart),
      .push       (q_push),
      .push_entry (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (q_head)
   );

   bb3_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .eff_width  (eff_width),
      .eff_height (eff_height),
      .q_valid    (q_valid),
      .q_entry    (q_head),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/bb3_queue.sv
// Short word queue between the blur front end and the window back end.
// Depends on bb3_pkg for the entry type and depth.
`default_nettype none

module bb3_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire bb3_pkg::qent_type push_entry,
   output logic                  full,
   input  wire logic             pop,
   output logic                  valid,
   output bb3_pkg::qent_type     head
);
   import bb3_pkg::*;

   qent_type                entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]         count_ff, count_in;
   logic                    do_push, do_pop;

   always_comb begin
      full      = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
      valid     = count_ff != '0;
      head      = entries_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && valid;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/bb3_front.sv
// Front end of the box blur: accepts words, drops misplaced ones, tracks the
// input raster and owns the two line stores. Depends on bb3_pkg.
`default_nettype none

module bb3_front #(
   parameter int MAX_WIDTH = 1024,
   localparam int CW = $clog2(MAX_WIDTH + 1),
   localparam int AW = $clog2(MAX_WIDTH)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 restart,
   input  wire logic [CW-1:0]        eff_width,
   input  wire logic [15:0]          eff_height,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire bb3_pkg::req_word_type req_word,
   output logic                      q_push,
   output bb3_pkg::qent_type         q_entry,
   input  wire logic                 q_full
);
   import bb3_pkg::*;

   typedef struct packed {
      rgb_type upper;
      rgb_type middle;
   } pair_type;

   pair_type          lines_mem [MAX_WIDTH];

   logic [CW-1:0]     in_column_ff, in_column_in;
   logic [15:0]       in_row_ff, in_row_in;
   logic              b_valid_ff;
   logic [AW-1:0]     b_addr_ff;
   rgb_type           b_pix_ff;
   logic              b_due_ff, b_last_ff;
   logic              fwd_ff;
   pair_type          fwd_data_ff;
   pair_type          rd_ff;

   logic              advance, flush, in_done, take, due, last;
   logic [AW-1:0]     rd_addr;
   rgb_type           pix;
   pair_type          b_pair;
   logic [CW-1:0]     col_inc;

   always_comb begin
      advance   = !b_valid_ff || !q_full;
      req_stall = !advance;
      flush     = req_word.opcode == OP_FLUSH;
      in_done   = in_row_ff >= eff_height;
      take      = req_valid && advance && (flush == in_done);
      rd_addr   = (in_column_ff < eff_width) ? in_column_ff[AW-1:0] : '0;
      pix       = flush ? '0 : {req_word.red_in, req_word.green_in, req_word.blue_in};
      due       = (in_row_ff > 16'd1) || ((in_row_ff == 16'd1) && (in_column_ff != '0));
      last      = flush && (in_column_ff == eff_width);
      col_inc   = in_column_ff + 1'b1;

      in_column_in = col_inc;
      in_row_in    = in_row_ff;
      if (last) begin
         in_column_in = '0;
         in_row_in    = '0;
      end else if (!flush && (col_inc >= eff_width)) begin
         in_column_in = '0;
         in_row_in    = in_row_ff + 1'b1;
      end

      // The read issued with this word missed the previous word's write: forward it.
      b_pair          = fwd_ff ? fwd_data_ff : rd_ff;
      q_push          = b_valid_ff && !q_full;
      q_entry.upper   = b_pair.upper;
      q_entry.middle  = b_pair.middle;
      q_entry.pix     = b_pix_ff;
      q_entry.due     = b_due_ff;
      q_entry.last    = b_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff <= '0;
         in_row_ff    <= '0;
         b_valid_ff   <= 1'b0;
      end else if (restart) begin
         in_column_ff <= '0;
         in_row_ff    <= '0;
         b_valid_ff   <= 1'b0;
      end else begin
         if (advance) begin
            b_valid_ff <= take;
         end
         if (take) begin
            in_column_ff <= in_column_in;
            in_row_ff    <= in_row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         b_addr_ff   <= rd_addr;
         b_pix_ff    <= pix;
         b_due_ff    <= due;
         b_last_ff   <= last;
         fwd_ff      <= b_valid_ff && (b_addr_ff == rd_addr);
         fwd_data_ff <= '{upper: b_pair.middle, middle: b_pix_ff};
      end
   end

   // Upper takes the old middle, middle takes the new pixel.
   always_ff @(posedge clock) begin
      if (take) begin
         rd_ff <= lines_mem[rd_addr];
      end
      if (q_push) begin
         lines_mem[b_addr_ff] <= '{upper: b_pair.middle, middle: b_pix_ff};
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/bb3_back.sv
// Back end of the box blur: 3x3 window, output raster, masked sums and the
// divide by the in-frame neighbor count. Depends on bb3_pkg.
`default_nettype none

module bb3_back #(
   parameter int MAX_WIDTH = 1024,
   localparam int CW = $clog2(MAX_WIDTH + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  restart,
   input  wire logic [CW-1:0]         eff_width,
   input  wire logic [15:0]           eff_height,
   input  wire logic                  q_valid,
   input  wire bb3_pkg::qent_type     q_entry,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output bb3_pkg::rsp_word_type      rsp_word
);
   import bb3_pkg::*;

   // window index: [column: left, center, right][row: up, center, down]
   rgb_type           window_ff [3][3];
   rgb_type           window_in [3][3];
   rgb_type           base [3][3];

   logic [CW-1:0]     out_col_ff;
   logic [15:0]       out_row_ff;

   logic              s1_valid_ff, s1_last_ff;
   logic [2:0]        s1_col_en_ff, s1_row_en_ff;
   logic [3:0]        s1_count_ff;

   logic              s2_valid_ff, s2_last_ff;
   logic [2:0][11:0]  s2_sum_ff;
   logic [3:0]        s2_count_ff;

   logic              rsp_valid_ff;
   rsp_word_type      rsp_word_ff;

   logic              en, take_due, left, right, up, down;
   logic [1:0]        cols, rows;
   logic [3:0]        count;
   logic [2:0][11:0]  sum;
   logic [2:0][7:0]   quot;
   logic [11:0]       dividend;
   logic [14:0]       recip;
   logic [26:0]       prod;

   always_comb begin
      en        = !rsp_valid_ff || !rsp_stall;
      q_pop     = q_valid && en;
      take_due  = q_pop && q_entry.due;
      left      = out_col_ff != '0;
      right     = out_col_ff != (eff_width - 1'b1);
      up        = out_row_ff != '0;
      down      = out_row_ff != (eff_height - 1'b1);
      cols      = 2'd1 + {1'b0, left} + {1'b0, right};
      rows      = 2'd1 + {1'b0, up} + {1'b0, down};
      count     = 4'(cols) * 4'(rows);
      rsp_valid = rsp_valid_ff;
      rsp_word  = rsp_word_ff;
   end

   // Clear the window once the frame-end result has taken its sums, then push.
   always_comb begin
      for (int ci = 0; ci < 3; ci++) begin
         for (int ri = 0; ri < 3; ri++) begin
            base[ci][ri] = (s1_valid_ff && s1_last_ff) ? '0 : window_ff[ci][ri];
         end
      end
      for (int ci = 0; ci < 3; ci++) begin
         for (int ri = 0; ri < 3; ri++) begin
            window_in[ci][ri] = base[ci][ri];
         end
      end
      if (q_pop) begin
         for (int ri = 0; ri < 3; ri++) begin
            window_in[0][ri] = base[1][ri];
            window_in[1][ri] = base[2][ri];
         end
         window_in[2][0] = q_entry.upper;
         window_in[2][1] = q_entry.middle;
         window_in[2][2] = q_entry.pix;
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum[ch] = '0;
         for (int ci = 0; ci < 3; ci++) begin
            for (int ri = 0; ri < 3; ri++) begin
               if (s1_col_en_ff[ci] && s1_row_en_ff[ri]) begin
                  sum[ch] = sum[ch] + 12'(window_ff[ci][ri][ch]);
               end
            end
         end
      end
   end

   // Divide by 1, 2, 3, 4, 6 or 9: shifts, or a reciprocal multiply.
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         dividend = (s2_count_ff == 4'd6) ? (s2_sum_ff[ch] >> 1) : s2_sum_ff[ch];
         recip    = (s2_count_ff == 4'd9) ? DIV9_RECIP : DIV3_RECIP;
         prod     = 27'(dividend) * 27'(recip);
         case (s2_count_ff)
            4'd2:                quot[ch] = s2_sum_ff[ch][8:1];
            4'd4:                quot[ch] = s2_sum_ff[ch][9:2];
            4'd3, 4'd6, 4'd9:    quot[ch] = prod[RECIP_SHIFT +: 8];
            default:             quot[ch] = s2_sum_ff[ch][7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         for (int ci = 0; ci < 3; ci++) begin
            for (int ri = 0; ri < 3; ri++) begin
               window_ff[ci][ri] <= '0;
            end
         end
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         window_ff    <= window_in;
         s1_valid_ff  <= take_due;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
         if (take_due) begin
            if (q_entry.last) begin
               out_col_ff <= '0;
               out_row_ff <= '0;
            end else if ((out_col_ff + 1'b1) >= eff_width) begin
               out_col_ff <= '0;
               out_row_ff <= out_row_ff + 1'b1;
            end else begin
               out_col_ff <= out_col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (take_due) begin
            s1_last_ff   <= q_entry.last;
            s1_col_en_ff <= {right, 1'b1, left};
            s1_row_en_ff <= {down, 1'b1, up};
            s1_count_ff  <= count;
         end
         s2_last_ff  <= s1_last_ff;
         s2_sum_ff   <= sum;
         s2_count_ff <= s1_count_ff;
         rsp_word_ff <= '{red_out: quot[2], green_out: quot[1], blue_out: quot[0],
                          frame_end: s2_last_ff};
      end
   end

endmodule

`default_nettype wire
